// ===== hdl/rpq_pkg.sv =====
// ----------------------------------------------------------------------------
// rpq_pkg: shared types and constants of the ranked priority queue
// Record layout, request and status codes, and the service order rule.
// ----------------------------------------------------------------------------
package rpq_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int SCORE_W  = 10;
    localparam int ROLL_W   = 16;
    localparam int TAG_W    = 16;
    localparam int REC_W    = SCORE_W + ROLL_W + TAG_W;
    localparam int TDATA_W  = ((REC_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - REC_W;
    localparam int TUSER_W  = 2;

    // Name tag in the lowest bits, then roll number, then score.
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [ROLL_W-1:0]  roll;
        logic [TAG_W-1:0]   name_tag;
    } rec_t;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_PEEK   = 2'd1,
        MODE_POP    = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_SHOWN = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;     // Input side may take a request.
        logic exec;      // Apply the held request to the store.
        logic load_out;  // Load the result register.
    } rpq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic nop;       // Held request asks for no action.
        logic out_free;  // Result register can take a new result.
    } rpq_stat_t;

    // True if record a is served before record b, where b is the older one.
    function automatic logic rec_beats(input rec_t a, input rec_t b);
        logic res;
        if (a.score != b.score) begin
            res = (a.score > b.score);
        end else begin
            res = (a.roll < b.roll);
        end
        return res;
    endfunction

endpackage

// ===== hdl/rpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpq_ctrl: request sequencer of the ranked priority queue
// Steps each request through capture, store update and result load.
// ----------------------------------------------------------------------------
module rpq_ctrl
    import rpq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  rpq_stat_t dp_stat,
    output rpq_cmd_t  dp_cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // A request with no action produces no result.
                state_next = dp_stat.nop ? ST_IDLE : ST_RESP;
            end
            ST_RESP: begin
                if (dp_stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        dp_cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                dp_cmd.ready = 1'b1;
            end
            ST_EXEC: begin
                dp_cmd.exec = 1'b1;
            end
            ST_RESP: begin
                dp_cmd.load_out = dp_stat.out_free;
            end
            default: begin
                dp_cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/rpq_datapath.sv =====
// ----------------------------------------------------------------------------
// rpq_datapath: sorted record array and result register
// Keeps records in service order, head in cell zero, oldest first on ties.
// ----------------------------------------------------------------------------
module rpq_datapath
    import rpq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  rpq_cmd_t            dp_cmd,
    output rpq_stat_t           dp_stat,
    input  logic                s_tvalid,
    input  logic [TDATA_W-1:0]  s_tdata,
    input  logic [TUSER_W-1:0]  s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,
    output logic [TUSER_W-1:0]  m_tuser
);

    mode_t             mode_reg;
    rec_t              req_reg;
    rec_t              cell_reg [CAPACITY];
    rec_t              cell_next [CAPACITY];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              drop_reg;
    logic              drop_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    status_t           m_status_reg;
    rec_t              m_rec_reg;

    logic              full;
    logic              empty;
    logic              insert_en;
    logic              pop_en;
    logic [CAPACITY-1:0] stay;

    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign insert_en = dp_cmd.exec && (mode_reg == MODE_INSERT) && !full;
    assign pop_en    = dp_cmd.exec && (mode_reg == MODE_POP) && !empty;

    // Request capture.
    always_ff @(posedge aclk) begin
        if (dp_cmd.ready && s_tvalid) begin
            mode_reg <= mode_t'(s_tuser);
            req_reg  <= rec_t'(s_tdata[REC_W-1:0]);
        end
    end

    // A valid cell keeps its record on insert unless the new one is served
    // before it; equal keys leave the new record behind the older ones.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign stay[i] = (count_reg > CNT_W'(i)) && !rec_beats(req_reg, cell_reg[i]);

        if (i == 0) begin : g_first
            always_comb begin
                cell_next[i] = cell_reg[i];
                if (insert_en) begin
                    if (!stay[i]) begin
                        cell_next[i] = req_reg;
                    end
                end else if (pop_en) begin
                    cell_next[i] = cell_reg[i+1];
                end
            end
        end else if (i == CAPACITY - 1) begin : g_last
            always_comb begin
                cell_next[i] = cell_reg[i];
                if (insert_en && !stay[i]) begin
                    cell_next[i] = stay[i-1] ? req_reg : cell_reg[i-1];
                end
            end
        end else begin : g_mid
            always_comb begin
                cell_next[i] = cell_reg[i];
                if (insert_en) begin
                    if (!stay[i]) begin
                        cell_next[i] = stay[i-1] ? req_reg : cell_reg[i-1];
                    end
                end else if (pop_en) begin
                    cell_next[i] = cell_reg[i+1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            cell_reg[i] <= cell_next[i];
        end
    end

    always_comb begin
        count_next = count_reg;
        drop_next  = drop_reg;
        if (dp_cmd.exec) begin
            drop_next = (mode_reg == MODE_INSERT) && full;
            if (insert_en) begin
                count_next = count_reg + CNT_W'(1);
            end else if (pop_en) begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

    // Result register.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (dp_cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load_out) begin
            if (drop_reg) begin
                m_status_reg <= STAT_FULL;
                m_rec_reg    <= cell_reg[0];
            end else if (empty) begin
                m_status_reg <= STAT_EMPTY;
                m_rec_reg    <= '0;
            end else begin
                m_status_reg <= STAT_SHOWN;
                m_rec_reg    <= cell_reg[0];
            end
        end
    end

    assign dp_stat.nop      = (mode_reg == MODE_NOP);
    assign dp_stat.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_rec_reg};
    assign m_tuser  = m_status_reg;

endmodule

// ===== hdl/ranked_priority_queue.sv =====
// A taken request goes through the controller's capture, update and result steps in turn;
// the result register is loaded in the result step once it is free. A new request is
// taken only after the last one is through; a no-action request skips the result step.
// Insert and pop update the whole sorted cell array at once, in the update step.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
// ranked_priority_queue: bounded priority queue of scored records
// Serves the highest score first, then the lower roll number, then the oldest.
// ----------------------------------------------------------------------------
module ranked_priority_queue
    import rpq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,   // name_tag, roll_number, score, zero fill
    input  logic [TUSER_W-1:0]  s_tuser,   // mode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // head_name_tag, head_roll_number, head_score, zero fill
    output logic [TUSER_W-1:0]  m_tuser    // status
);

    rpq_cmd_t  dp_cmd;
    rpq_stat_t dp_stat;

    assign s_tready = dp_cmd.ready;

    rpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .dp_stat  (dp_stat),
        .dp_cmd   (dp_cmd)
    );

    rpq_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .dp_cmd   (dp_cmd),
        .dp_stat  (dp_stat),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== hdl/rpq_checker.sv =====
// ----------------------------------------------------------------------------
// rpq_checker: port-level checks of the ranked priority queue
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
module rpq_checker
    import rpq_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [TDATA_W-1:0]  s_tdata,
    input logic [TUSER_W-1:0]  s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [TDATA_W-1:0]  m_tdata,
    input logic [TUSER_W-1:0]  m_tuser
);

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // One request at a time: a taken request closes the input side.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in progress");

    // Status is always a defined code.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STAT_SHOWN || m_tuser == STAT_EMPTY ||
                      m_tuser == STAT_FULL))
        else $error("undefined status code");

    // An empty queue shows an all-zero head.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_EMPTY |-> m_tdata == '0)
        else $error("empty status with nonzero head");

endmodule

bind ranked_priority_queue rpq_checker u_rpq_checker (.*);
